/* sv/i64div_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i64div_pkg
// Shared types and constants for the 64-bit integer divider.
// ----------------------------------------------------------------------------
package i64div_pkg;

   localparam int DATA_WIDTH = 64;

   typedef struct packed {
      logic        func;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } i64div_req_type;

   typedef struct packed {
      logic [63:0] quotient;
      logic [63:0] remainder;
      logic        div_by_zero;
   } i64div_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } i64div_stat_type;

endpackage
`default_nettype wire

/* sv/i64div_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i64div_core
// Restoring shift-and-subtract unit: one quotient bit per cycle on unsigned
// operands.
// ----------------------------------------------------------------------------
module i64div_core #(
   parameter int WIDTH = i64div_pkg::DATA_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [WIDTH-1:0]            divisor,
   output logic [WIDTH-1:0]            quotient,
   output logic [WIDTH-1:0]            remainder,
   output i64div_pkg::i64div_stat_type status
);
   import i64div_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] den_ff;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff;
   logic             done_ff;

   logic             carry;
   logic [WIDTH-1:0] shifted;
   logic [WIDTH:0]   diff;
   logic             take;

   always_comb begin
      carry   = rem_ff[WIDTH-1];
      shifted = {rem_ff[WIDTH-2:0], num_ff[WIDTH-1]};
      diff    = {carry, shifted} - {1'b0, den_ff};
      take    = carry | ~diff[WIDTH];
      num_in  = {num_ff[WIDTH-2:0], 1'b0};
      rem_in  = take ? diff[WIDTH-1:0] : shifted;
      quo_in  = {quo_ff[WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CW'(WIDTH);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule
`default_nettype wire

/* sv/int64_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// int64_divider
// Signed/unsigned integer divider with quotient, remainder and zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one transaction: func (0 unsigned,
//   1 signed), dividend and divisor. rsp_valid/rsp_ready/rsp_data return one
//   transaction per request: quotient, remainder and div_by_zero.
//   From acceptance to rsp_valid, the block forms the operand magnitudes,
//   runs them through the shared restoring unit (one quotient bit per step),
//   collects the unit's result and applies sign correction into the output
//   register, which then presents the transaction.
//   A zero divisor bypasses the unit and goes from operand preparation
//   straight to sign correction.
//   The single subtract-and-shift unit takes one operation at a time;
//   req_ready is high only while no operation runs.
//   A new request may be taken while a finished response still waits.
//   When the receiver stalls, the response holds in the output register and
//   a following operation waits at its sign-correction step.
//   Reset clears the sequencer and rsp_valid; no response is pending after.
// ----------------------------------------------------------------------------
module int64_divider #(
   parameter int WIDTH = i64div_pkg::DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  i64div_pkg::i64div_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output i64div_pkg::i64div_rsp_type rsp_data
);
   import i64div_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FIX
   } state_type;

   state_type        state_ff;
   logic             rsp_valid_ff;
   i64div_rsp_type   rsp_data_ff;

   logic             func_ff;
   logic [WIDTH-1:0] a_ff;
   logic [WIDTH-1:0] b_ff;
   logic             neg_q_ff;
   logic             neg_r_ff;
   logic             dbz_ff;
   logic [WIDTH-1:0] res_q_ff;
   logic [WIDTH-1:0] res_r_ff;

   logic             neg_a;
   logic             neg_b;
   logic [WIDTH-1:0] mag_a;
   logic [WIDTH-1:0] mag_b;
   logic             b_zero;
   logic             core_start;
   logic [WIDTH-1:0] core_q;
   logic [WIDTH-1:0] core_r;
   i64div_stat_type  core_stat;
   logic [WIDTH-1:0] fix_q;
   logic [WIDTH-1:0] fix_r;
   logic             out_free;

   always_comb begin
      neg_a      = func_ff & a_ff[WIDTH-1];
      neg_b      = func_ff & b_ff[WIDTH-1];
      mag_a      = neg_a ? (~a_ff + 1'b1) : a_ff;
      mag_b      = neg_b ? (~b_ff + 1'b1) : b_ff;
      b_zero     = (b_ff == '0);
      core_start = (state_ff == ST_PREP) && !b_zero && !core_stat.busy;
      fix_q      = neg_q_ff ? (~res_q_ff + 1'b1) : res_q_ff;
      fix_r      = neg_r_ff ? (~res_r_ff + 1'b1) : res_r_ff;
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   i64div_core #(
      .WIDTH (WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .quotient  (core_q),
      .remainder (core_r),
      .status    (core_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FIX && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (b_zero) begin
                  state_ff <= ST_FIX;
               end else if (core_start) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (core_stat.done) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               if (out_free) begin
                  rsp_data_ff.quotient    <= 64'(fix_q);
                  rsp_data_ff.remainder   <= 64'(fix_r);
                  rsp_data_ff.div_by_zero <= dbz_ff;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff <= req_data.func;
         a_ff    <= req_data.dividend[WIDTH-1:0];
         b_ff    <= req_data.divisor[WIDTH-1:0];
      end
      if (state_ff == ST_PREP) begin
         if (b_zero) begin
            res_q_ff <= '1;
            res_r_ff <= a_ff;
            neg_q_ff <= 1'b0;
            neg_r_ff <= 1'b0;
            dbz_ff   <= 1'b1;
         end else begin
            neg_q_ff <= neg_a ^ neg_b;
            neg_r_ff <= neg_a;
            dbz_ff   <= 1'b0;
         end
      end
      if (state_ff == ST_RUN && core_stat.done) begin
         res_q_ff <= core_q;
         res_r_ff <= core_r;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* verif/int64_divider_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int64_divider_tb
// Drives signed and unsigned divisions into the divider with random bursts,
// gaps and response back-pressure, including one long stall that backs the
// block up. A behavioural divider predicts quotient, remainder and zero flag
// for each accepted request; responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module int64_divider_tb;
   import i64div_pkg::*;

   typedef enum logic {
      DIV_UNSIGNED = 1'b0,
      DIV_SIGNED   = 1'b1
   } div_mode_type;

   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam int RANDOM_ITEMS = 1050;
   localparam int STALL_AFTER  = 300;
   localparam int STALL_CYCLES = 600;
   localparam int DRAIN_CYCLES = 80;

   class division_checker;
      i64div_rsp_type pending_quotients[$];
      int unsigned    mismatches = 0;

      function i64div_rsp_type divide(i64div_req_type req);
         i64div_rsp_type res;
         logic [63:0]    mag_n;
         logic [63:0]    mag_d;
         logic [63:0]    q;
         logic [63:0]    r;
         logic           neg_n;
         logic           neg_d;
         res.div_by_zero = 1'b0;
         if (req.divisor == '0) begin
            res.quotient    = ALL_ONES;
            res.remainder   = req.dividend;
            res.div_by_zero = 1'b1;
         end else if (req.func == DIV_UNSIGNED) begin
            res.quotient  = req.dividend / req.divisor;
            res.remainder = req.dividend % req.divisor;
         end else begin
            neg_n = req.dividend[63];
            neg_d = req.divisor[63];
            mag_n = neg_n ? ~req.dividend + 64'd1 : req.dividend;
            mag_d = neg_d ? ~req.divisor + 64'd1 : req.divisor;
            q = mag_n / mag_d;
            r = mag_n % mag_d;
            res.quotient  = (neg_n != neg_d) ? ~q + 64'd1 : q;
            res.remainder = neg_n ? ~r + 64'd1 : r;
         end
         return res;
      endfunction

      function void note_request(i64div_req_type req);
         pending_quotients.push_back(divide(req));
      endfunction

      function void check_result(i64div_rsp_type got);
         i64div_rsp_type want;
         if (pending_quotients.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_quotients.pop_front();
         if (got.quotient !== want.quotient) begin
            $display("%0t: quotient expected %h actual %h", $time,
                     want.quotient, got.quotient);
            mismatches++;
         end
         if (got.remainder !== want.remainder) begin
            $display("%0t: remainder expected %h actual %h", $time,
                     want.remainder, got.remainder);
            mismatches++;
         end
         if (got.div_by_zero !== want.div_by_zero) begin
            $display("%0t: div_by_zero expected %b actual %b", $time,
                     want.div_by_zero, got.div_by_zero);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_quotients.size();
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   i64div_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   i64div_rsp_type rsp_data;

   division_checker sb = new();
   int unsigned     requests_taken = 0;
   int unsigned     burst_left = 0;

   int64_divider uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   task automatic send_request(input div_mode_type mode, input logic [63:0] n,
                               input logic [63:0] d);
      i64div_req_type item;
      int unsigned    gap;
      item.func     = mode;
      item.dividend = n;
      item.divisor  = d;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
      requests_taken++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: v = '0;
               1: v = 64'd1;
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               4: v = MOST_POS;
               default: v = ALL_ONES - 64'd1;
            endcase
         end
         1, 2: v = v >> $urandom_range(0, 63);
         3: v = ~(v >> $urandom_range(0, 63));
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(DIV_UNSIGNED, ALL_ONES, 64'd1);
      send_request(DIV_UNSIGNED, ALL_ONES, ALL_ONES);
      send_request(DIV_UNSIGNED, '0, 64'd1);
      send_request(DIV_UNSIGNED, ALL_ONES, '0);
      send_request(DIV_UNSIGNED, '0, '0);
      send_request(DIV_UNSIGNED, 64'd7, 64'd3);
      send_request(DIV_UNSIGNED, MOST_NEG, 64'd2);
      send_request(DIV_UNSIGNED, 64'd5, ALL_ONES);
      send_request(DIV_UNSIGNED, 64'h1234_5678_9abc_def0, 64'h0000_0001_0000_0001);
      send_request(DIV_SIGNED, MOST_NEG, ALL_ONES);
      send_request(DIV_SIGNED, MOST_NEG, 64'd1);
      send_request(DIV_SIGNED, MOST_NEG, MOST_NEG);
      send_request(DIV_SIGNED, -64'sd7, 64'd2);
      send_request(DIV_SIGNED, 64'd7, -64'sd2);
      send_request(DIV_SIGNED, -64'sd7, -64'sd2);
      send_request(DIV_SIGNED, MOST_POS, ALL_ONES);
      send_request(DIV_SIGNED, '0, ALL_ONES);
      send_request(DIV_SIGNED, ALL_ONES, '0);
      send_request(DIV_SIGNED, MOST_NEG, '0);
      send_request(DIV_SIGNED, ALL_ONES, MOST_NEG);
      send_request(DIV_SIGNED, 64'd100, 64'd7);
      send_request(DIV_SIGNED, MOST_POS, MOST_NEG);

      repeat (RANDOM_ITEMS) begin
         send_request(div_mode_type'($urandom_range(0, 1)), rand_operand(), rand_operand());
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // response side: check, then pick the next ready level
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      bit          held_off;
      bit          next_ready;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      held_off  = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if (!held_off && requests_taken >= STALL_AFTER) begin
            held_off  = 1'b1;
            hold_left = STALL_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (mode)
            0: next_ready = 1'b1;
            1: next_ready = $urandom_range(0, 1);
            2: next_ready = ($urandom_range(0, 4) == 0);
            default: next_ready = ~rsp_ready;
         endcase
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end
         rsp_ready <= next_ready;
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
